// ===== src/swts_pkg.sv =====
package swts_pkg;

   // default history depth
   localparam int DEFAULT_DEPTH = 64;

   // field widths
   localparam int VALUE_W  = 32;
   localparam int TIME_W   = 48;
   localparam int LENGTH_W = 7;
   localparam int SUM_W    = 38;
   localparam int STATUS_W = 2;

   // max_window register reset value
   localparam logic [LENGTH_W-1:0] MAX_WINDOW_RESET = 7'd64;

   // transaction kinds
   localparam logic KIND_PUSH  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

   typedef struct packed {
      logic                kind;
      logic [VALUE_W-1:0]  sample_value;
      logic [TIME_W-1:0]   sample_start;
      logic [TIME_W-1:0]   sample_end;
      logic [LENGTH_W-1:0] window_length;
   } req_payload_type;

   typedef struct packed {
      logic [SUM_W-1:0]    sum_value;
      logic [TIME_W-1:0]   window_start;
      logic [TIME_W-1:0]   window_end;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   // one history entry
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [TIME_W-1:0]  start;
      logic [TIME_W-1:0]  stop;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_LAST,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept_push;
      logic accept_query;
      logic issue;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic query_ok;
      logic last_issue;
      logic rsp_free;
   } stat_type;

endpackage

// ===== src/swts_ctrl.sv =====
module swts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_stall,
   input  swts_pkg::stat_type  stat,
   output swts_pkg::cmd_type   cmd
);

   swts_pkg::state_type state_ff;
   swts_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         swts_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_kind == swts_pkg::KIND_PUSH) begin
                  cmd.accept_push = 1'b1;
               end else begin
                  cmd.accept_query = 1'b1;
                  state_in = stat.query_ok ? swts_pkg::ST_ISSUE : swts_pkg::ST_RESULT;
               end
            end
         end
         swts_pkg::ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (stat.last_issue) begin
               state_in = swts_pkg::ST_LAST;
            end
         end
         swts_pkg::ST_LAST: begin
            state_in = swts_pkg::ST_RESULT;
         end
         swts_pkg::ST_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = swts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swts_pkg::ST_IDLE;
         end
      endcase
   end

   // walk always ends through the drain state
   a_last_after_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swts_pkg::ST_LAST) |-> $past(state_ff == swts_pkg::ST_ISSUE))
      else $error("drain state not preceded by issue");

   // a result waiting on a free output leaves on the next edge
   a_result_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swts_pkg::ST_RESULT && stat.rsp_free) |=> (state_ff == swts_pkg::ST_IDLE))
      else $error("result state did not return to idle");

   // nothing enters during a walk
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != swts_pkg::ST_IDLE) |-> !(cmd.accept_push || cmd.accept_query))
      else $error("transaction accepted while busy");

endmodule

// ===== src/swts_datapath.sv =====
module swts_datapath #(
   parameter int DEPTH = swts_pkg::DEFAULT_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [swts_pkg::LENGTH_W-1:0]        max_window,
   input  swts_pkg::req_payload_type            req_payload,
   input  swts_pkg::cmd_type                    cmd,
   output swts_pkg::stat_type                   stat,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output swts_pkg::rsp_payload_type            rsp_payload
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > swts_pkg::LENGTH_W) ? CNT_W : swts_pkg::LENGTH_W) + 1;
   localparam int SUM_W = swts_pkg::SUM_W;

   // history memory
   swts_pkg::entry_type mem [DEPTH];
   swts_pkg::entry_type rd_data_ff;

   logic [PTR_W-1:0] wp_ff;
   logic [PTR_W-1:0] wp_in;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] remaining_ff;
   logic             first_ff;
   logic             rd_vld_ff;
   logic             rd_first_ff;
   logic             rd_last_ff;

   logic [SUM_W-1:0]              sum_ff;
   logic [swts_pkg::TIME_W-1:0]   start_ff;
   logic [swts_pkg::TIME_W-1:0]   end_ff;
   logic [swts_pkg::STATUS_W-1:0] status_ff;
   logic [swts_pkg::STATUS_W-1:0] status_in;
   logic                          rsp_valid_ff;
   swts_pkg::rsp_payload_type     rsp_payload_ff;

   logic [CMP_W-1:0] mw_ext;
   logic [CMP_W-1:0] cap;
   logic [CMP_W-1:0] k_ext;
   logic [CMP_W-1:0] fill_ext;
   logic [CMP_W-1:0] n_len;
   logic [SUM_W:0]   sum_add;
   logic [SUM_W-1:0] sum_in;

   // effective capacity clamped to 1..DEPTH
   always_comb begin
      mw_ext = CMP_W'(max_window);
      if (mw_ext == '0) begin
         cap = CMP_W'(1);
      end else if (mw_ext > CMP_W'(DEPTH)) begin
         cap = CMP_W'(DEPTH);
      end else begin
         cap = mw_ext;
      end
   end

   // query decode and window length
   always_comb begin
      k_ext    = CMP_W'(req_payload.window_length);
      fill_ext = CMP_W'(fill_ff);
      if (k_ext == '0 || k_ext > cap) begin
         status_in = swts_pkg::STATUS_INVALID;
      end else if (fill_ext == '0) begin
         status_in = swts_pkg::STATUS_EMPTY;
      end else begin
         status_in = swts_pkg::STATUS_OK;
      end
      n_len = (k_ext < fill_ext) ? k_ext : fill_ext;
   end

   // push pointer and fill count
   always_comb begin
      wp_in   = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
      fill_in = (fill_ext >= cap) ? cap[CNT_W-1:0] : fill_ff + CNT_W'(1);
   end

   // read pointer steps back from the newest entry
   always_comb begin
      if (cmd.accept_query) begin
         rd_ptr_in = (wp_ff == '0) ? PTR_W'(DEPTH - 1) : wp_ff - PTR_W'(1);
      end else begin
         rd_ptr_in = (rd_ptr_ff == '0) ? PTR_W'(DEPTH - 1) : rd_ptr_ff - PTR_W'(1);
      end
   end

   // saturating accumulate
   always_comb begin
      sum_add = {1'b0, sum_ff} + (SUM_W + 1)'(rd_data_ff.value);
      sum_in  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.accept_push) begin
         mem[wp_ff] <= '{value: req_payload.sample_value,
                         start: req_payload.sample_start,
                         stop:  req_payload.sample_end};
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   // history control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rd_first_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         first_ff     <= 1'b0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept_push) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
         if (cmd.accept_query) begin
            remaining_ff <= n_len[CNT_W-1:0];
            first_ff     <= 1'b1;
         end else if (cmd.issue) begin
            remaining_ff <= remaining_ff - CNT_W'(1);
            first_ff     <= 1'b0;
         end
         rd_vld_ff   <= cmd.issue;
         rd_first_ff <= cmd.issue && first_ff;
         rd_last_ff  <= cmd.issue && (remaining_ff == CNT_W'(1));
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // query accumulators and output register
   always_ff @(posedge clock) begin
      if (cmd.accept_query || cmd.issue) begin
         rd_ptr_ff <= rd_ptr_in;
      end
      if (cmd.accept_query) begin
         sum_ff    <= '0;
         start_ff  <= '0;
         end_ff    <= '0;
         status_ff <= status_in;
      end else if (rd_vld_ff) begin
         sum_ff <= sum_in;
         if (rd_first_ff) begin
            end_ff <= rd_data_ff.stop;
         end
         if (rd_last_ff) begin
            start_ff <= rd_data_ff.start;
         end
      end
      if (cmd.load_rsp) begin
         rsp_payload_ff <= '{sum_value:    sum_ff,
                             window_start: start_ff,
                             window_end:   end_ff,
                             status:       status_ff};
      end
   end

   // status to controller
   always_comb begin
      stat.query_ok   = (status_in == swts_pkg::STATUS_OK);
      stat.last_issue = (remaining_ff == CNT_W'(1));
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a read is issued only while entries remain
   a_issue_remaining: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (remaining_ff != '0))
      else $error("read issued with no entries left");

   // result is loaded only after the last read has been summed
   a_load_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rd_vld_ff)
      else $error("result loaded while a read is in flight");

   // history never holds more than the store depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_push |=> (fill_ff <= CNT_W'(DEPTH)) && (fill_ff != '0))
      else $error("fill count out of range after push");

endmodule

// ===== src/sliding_window_tick_sum_top.sv =====
// sliding window tick sum
// keeps the newest samples (value, start, end) in a circular history and
// answers window-sum queries over the newest min(k, count) samples.
// req channel: valid/stall, payload kind selects push or query. a push
// writes one entry and the sequencer stays idle. a valid query walks the
// history through the single memory read port, one entry per cycle, then
// passes a drain state and a result state that loads the output register;
// the input is stalled from acceptance until the sequencer is idle again.
// invalid or empty queries skip the walk and go to the result state.
// rsp channel: valid/stall with an output register, so new transactions are
// accepted while a result waits; a stalled result holds, and a query that
// finishes behind it waits until the output register frees.
// csr channel: valid/ready write of max_window, always ready, applied to the
// next transaction. reset is synchronous: pointer and fill count go to zero,
// max_window to 64; the history memory is not cleared, no sweep is needed.
module sliding_window_tick_sum_top #(
   parameter int DEPTH = swts_pkg::DEFAULT_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  swts_pkg::req_payload_type     req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output swts_pkg::rsp_payload_type     rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [swts_pkg::LENGTH_W-1:0] csr_data
);

   logic [swts_pkg::LENGTH_W-1:0] max_window_ff;
   swts_pkg::cmd_type             cmd;
   swts_pkg::stat_type            stat;

   // max_window register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_window_ff <= swts_pkg::MAX_WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         max_window_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // sequencer
   swts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // history and accumulation
   swts_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .max_window  (max_window_ff),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
